/* rtl/core/mi3_pkg.sv */
// shared types, defaults and operand tables for the 3x3 matrix inverse
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

	localparam int ELEM_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int Q_DEPTH       = 2;
	localparam int N_ELEM        = 9;
	localparam int COF_STEPS     = 18;
	localparam int MUL_STEPS     = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FLUSH,
		ST_DSET,
		ST_DRUN,
		ST_EMIT
	} state_t;

	// cofactor c uses step 2c (first product) and 2c+1 (subtracted product)
	localparam logic [3:0] OPA_TBL [COF_STEPS] = '{
		4'd4, 4'd5, 4'd5, 4'd3, 4'd3, 4'd4,
		4'd7, 4'd8, 4'd8, 4'd6, 4'd6, 4'd7,
		4'd1, 4'd2, 4'd2, 4'd0, 4'd0, 4'd1
	};
	localparam logic [3:0] OPB_TBL [COF_STEPS] = '{
		4'd8, 4'd7, 4'd6, 4'd8, 4'd7, 4'd6,
		4'd2, 4'd1, 4'd0, 4'd2, 4'd1, 4'd0,
		4'd5, 4'd4, 4'd3, 4'd5, 4'd4, 4'd3
	};

endpackage
`default_nettype wire

/* rtl/core/mi3_front.sv */
// front end: collects nine elements and hands the full matrix to the queue
`timescale 1ns / 1ps
`default_nettype none
module mi3_front import mi3_pkg::*; #(
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ELEM_BITS-1:0]           in_elem,
	output logic                                push,
	output logic [N_ELEM*ELEM_BITS-1:0]         push_data,
	input  wire logic                           push_ready
);

	logic [3:0]           cnt_q;
	logic [ELEM_BITS-1:0] ld_q [8];
	logic                 accept;
	logic                 ninth;

	assign ninth    = (cnt_q == 4'(N_ELEM - 1));
	assign in_ready = !ninth || push_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept && ninth;

	always_comb begin
		for (int i = 0; i < N_ELEM - 1; i++) begin
			push_data[i*ELEM_BITS +: ELEM_BITS] = ld_q[i];
		end
		push_data[(N_ELEM-1)*ELEM_BITS +: ELEM_BITS] = in_elem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= ninth ? 4'd0 : cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !ninth) begin
			ld_q[cnt_q[2:0]] <= in_elem;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/mi3_fifo.sv */
// short matrix queue between the loader and the compute engine
`timescale 1ns / 1ps
`default_nettype none
module mi3_fifo import mi3_pkg::*; #(
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [N_ELEM*ELEM_BITS-1:0]    push_data,
	output logic                                push_ready,
	output logic                                pop_valid,
	output logic [N_ELEM*ELEM_BITS-1:0]         pop_data,
	input  wire logic                           pop
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	logic [N_ELEM*ELEM_BITS-1:0] mem_q [Q_DEPTH];
	logic [PW-1:0]               wr_q;
	logic [PW-1:0]               rd_q;
	logic [CW-1:0]               cnt_q;

	assign push_ready = (cnt_q != CW'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(Q_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/mi3_back.sv */
// compute engine: cofactors and determinant on one multiplier, serial divider, output register
`timescale 1ns / 1ps
`default_nettype none
module mi3_back import mi3_pkg::*; #(
	parameter int ELEM_BITS = ELEM_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [N_ELEM*ELEM_BITS-1:0]    in_data,
	output logic                                in_pop,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          out_row,
	output logic [1:0]                          out_col,
	output logic [ELEM_BITS-1:0]                out_inv,
	output logic [ELEM_BITS-1:0]                out_det,
	output logic                                out_sing,
	output logic                                out_last
);

	localparam int E   = ELEM_BITS;
	localparam int F   = FRAC_BITS;
	localparam int ML  = E + 1;
	localparam int PW  = 2 * ML;
	localparam int CW  = 2 * E + 1;
	localparam int DW  = 3 * E + 3;
	localparam int WW  = 4 * E + 2 * F + 2;
	localparam int BCW = $clog2(E + 1);

	state_t state_q, state_d;

	logic [E-1:0]            mat_q [N_ELEM];
	logic [CW-1:0]           cof_q [N_ELEM];
	logic [DW-1:0]           det_q;
	logic [4:0]              step_q;
	logic [4:0]              ptag_s1;
	logic                    pvld_s1;
	logic signed [PW-1:0]    prod_s1;
	logic signed [ML-1:0]    opa;
	logic signed [ML-1:0]    opb;
	logic [4:0]              dj;
	logic [3:0]              cidx;
	logic [1:0]              r_q, c_q;
	logic [BCW-1:0]          bcnt_q;
	logic [WW-1:0]           rem_q, dsh_q;
	logic [E:0]              q_q;
	logic                    sat_q, neg_q, sing_q;
	logic [E-1:0]            det_out_q;

	logic                    ovalid_q, osing_q, olast_q;
	logic [1:0]              orow_q, ocol_q;
	logic [E-1:0]            oinv_q, odet_q;

	logic                    emit_go, last_pos, det_zero;
	logic [3:0]              tidx;
	logic [CW-1:0]           cs, cmag;
	logic [DW-1:0]           dmag, drnd, dq, dlim;
	logic [DW-1:0]           dval;
	logic [WW-1:0]           num, den_sh;
	logic                    sat_d;
	logic [E:0]              lim, qs, qv;

	assign det_zero = (det_q == '0);
	assign last_pos = (r_q == 2'd2) && (c_q == 2'd2);
	assign emit_go  = (state_q == ST_EMIT) && (!ovalid_q || out_ready);
	assign in_pop   = (state_q == ST_IDLE) && in_valid;
	assign cidx     = ptag_s1[4:1];

	// shared multiplier operands
	always_comb begin
		dj  = step_q - 5'(COF_STEPS);
		opa = '0;
		opb = '0;
		if (step_q < 5'(COF_STEPS)) begin
			opa = {mat_q[OPA_TBL[step_q]][E-1], mat_q[OPA_TBL[step_q]]};
			opb = {mat_q[OPB_TBL[step_q]][E-1], mat_q[OPB_TBL[step_q]]};
		end else begin
			opa = {mat_q[{2'b00, dj[2:1]}][E-1], mat_q[{2'b00, dj[2:1]}]};
			// split the cofactor: unsigned low half, signed high half
			opb = dj[0] ? cof_q[{2'b00, dj[2:1]}][CW-1:E]
			            : {1'b0, cof_q[{2'b00, dj[2:1]}][E-1:0]};
		end
	end

	// divider setup and result formatting
	always_comb begin
		tidx   = 4'({c_q, 1'b0}) + 4'(c_q) + 4'(r_q);
		cs     = cof_q[tidx];
		cmag   = cs[CW-1] ? (~cs + CW'(1)) : cs;
		dmag   = det_q[DW-1] ? (~det_q + DW'(1)) : det_q;
		num    = (WW'(cmag) << (2 * F + 1)) + WW'(dmag);
		den_sh = WW'(dmag) << (E + 1);
		sat_d  = num >= (WW'(dmag) << (E + 2));

		drnd   = (dmag + (DW'(1) << (2 * F - 1))) >> (2 * F);
		dlim   = det_q[DW-1] ? (DW'(1) << (E - 1)) : ((DW'(1) << (E - 1)) - DW'(1));
		dq     = (drnd > dlim) ? dlim : drnd;
		dval   = det_q[DW-1] ? (~dq + DW'(1)) : dq;

		lim    = neg_q ? ((E+1)'(1) << (E - 1)) : (((E+1)'(1) << (E - 1)) - (E+1)'(1));
		qs     = (sat_q || (q_q > lim)) ? lim : q_q;
		qv     = neg_q ? (~qs + (E+1)'(1)) : qs;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == 5'(MUL_STEPS - 1)) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_DSET;
			end
			ST_DSET: begin
				state_d = det_zero ? ST_EMIT : ST_DRUN;
			end
			ST_DRUN: begin
				if (bcnt_q == BCW'(E)) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_go) state_d = last_pos ? ST_IDLE : ST_DSET;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			pvld_s1  <= 1'b0;
			r_q      <= '0;
			c_q      <= '0;
			bcnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pvld_s1 <= (state_q == ST_MUL);
			if (in_pop) begin
				step_q <= '0;
				r_q    <= '0;
				c_q    <= '0;
			end else if (state_q == ST_MUL) begin
				step_q <= step_q + 5'd1;
			end
			if (state_q == ST_DSET) begin
				bcnt_q <= '0;
			end else if (state_q == ST_DRUN) begin
				bcnt_q <= bcnt_q + BCW'(1);
			end
			if (emit_go && !last_pos) begin
				if (c_q == 2'd2) begin
					c_q <= 2'd0;
					r_q <= r_q + 2'd1;
				end else begin
					c_q <= c_q + 2'd1;
				end
			end
			if (emit_go) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		ptag_s1 <= step_q;
		prod_s1 <= opa * opb;
		if (in_pop) begin
			for (int i = 0; i < N_ELEM; i++) begin
				mat_q[i] <= in_data[i*E +: E];
			end
		end
		if (in_pop) begin
			det_q <= '0;
		end else if (pvld_s1 && ptag_s1 >= 5'(COF_STEPS)) begin
			if (ptag_s1[0]) begin
				det_q <= det_q + ({{(DW-PW){prod_s1[PW-1]}}, prod_s1} << E);
			end else begin
				det_q <= det_q + {{(DW-PW){prod_s1[PW-1]}}, prod_s1};
			end
		end
		if (pvld_s1 && ptag_s1 < 5'(COF_STEPS)) begin
			if (ptag_s1[0]) begin
				cof_q[cidx] <= cof_q[cidx] - prod_s1[CW-1:0];
			end else begin
				cof_q[cidx] <= prod_s1[CW-1:0];
			end
		end
		if (state_q == ST_DSET) begin
			rem_q     <= num;
			dsh_q     <= den_sh;
			q_q       <= '0;
			sat_q     <= sat_d;
			neg_q     <= cs[CW-1] ^ det_q[DW-1];
			sing_q    <= det_zero;
			det_out_q <= det_zero ? '0 : dval[E-1:0];
		end else if (state_q == ST_DRUN) begin
			// one quotient bit per cycle
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[E-1:0], 1'b1};
			end else begin
				q_q   <= {q_q[E-1:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (emit_go) begin
			orow_q  <= r_q;
			ocol_q  <= c_q;
			oinv_q  <= sing_q ? '0 : qv[E-1:0];
			odet_q  <= det_out_q;
			osing_q <= sing_q;
			olast_q <= last_pos;
		end
	end

	assign out_valid = ovalid_q;
	assign out_row   = orow_q;
	assign out_col   = ocol_q;
	assign out_inv   = oinv_q;
	assign out_det   = odet_q;
	assign out_sing  = osing_q;
	assign out_last  = olast_q;

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRUN && !sat_q) |-> (rem_q < {dsh_q, 1'b0}))
		else $error("divider remainder out of range");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && osing_q) |-> (oinv_q == '0 && odet_q == '0))
		else $error("singular word carries nonzero data");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && last_pos) |=> (state_q == ST_IDLE && ovalid_q && olast_q))
		else $error("last word did not end the matrix");

endmodule
`default_nettype wire

/* rtl/core/matrix_inverse_3x3.sv */
// top level of the 3x3 fixed-point matrix inverse
// Usage: the slave stream takes one matrix element per word, signed fixed point,
// row-major order. After every ninth word the matrix goes into a two-entry queue and
// the compute engine derives cofactors and determinant on one shared multiplier,
// then divides each adjugate entry by the determinant with a serial divider.
// The master stream gives nine words per matrix, row-major, each with row, column,
// inverse element and determinant; tuser is the singular flag, tlast marks the ninth.
// The serial divider makes one quotient bit per cycle; the engine works on one matrix
// at a time. Loading overlaps with computing while the queue has room.
// Reset clears the load count, the queue and the engine; stored data needs no clear.
// A receiver stall holds the output word; the engine waits on the next result and the
// front keeps loading, holding back only a matrix's ninth element while the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int ELEM_BITS = ELEM_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  wire logic [((ELEM_BITS+7)/8)*8-1:0]         s_axis_tdata,  // elem_value
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	output logic [((2*ELEM_BITS+4+7)/8)*8-1:0]          m_axis_tdata,  // out_row, out_col, inv_value, det_value
	output logic                                        m_axis_tuser,  // singular
	output logic                                        m_axis_tlast
);

	localparam int OTW = ((2 * ELEM_BITS + 4 + 7) / 8) * 8;

	logic                              push, push_ready;
	logic [N_ELEM*ELEM_BITS-1:0]       push_data;
	logic                              q_valid, q_pop;
	logic [N_ELEM*ELEM_BITS-1:0]       q_data;
	logic [1:0]                        out_row, out_col;
	logic [ELEM_BITS-1:0]              inv_value, det_value;

	mi3_front #(.ELEM_BITS(ELEM_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_elem    (s_axis_tdata[ELEM_BITS-1:0]),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	mi3_fifo #(.ELEM_BITS(ELEM_BITS)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_data),
		.pop        (q_pop)
	);

	mi3_back #(.ELEM_BITS(ELEM_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_data   (q_data),
		.in_pop    (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_inv   (inv_value),
		.out_det   (det_value),
		.out_sing  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = OTW'({det_value, inv_value, out_col, out_row});

endmodule
`default_nettype wire

/* tb/tb.sv */
// testbench for the 3x3 fixed-point matrix inverse: stream checks against a built-in predictor
`timescale 1ns / 1ps
module tb;
	import mi3_pkg::*;

	localparam int EB = ELEM_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int IW = ((EB+7)/8)*8;
	localparam int OW = ((2*EB+4+7)/8)*8;
	localparam int WATCH_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]    row;
		logic [1:0]    col;
		logic [EB-1:0] inv;
		logic [EB-1:0] det;
		logic          sing;
		logic          last;
	} inv_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OW-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	matrix_inverse_3x3 dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	inv_word_t expected_words[$];
	logic signed [EB-1:0] elems[9];
	int load_cnt = 0;
	int fails = 0;
	int idle_cycles = 0;
	bit rx_idle = 1;

	// signed n / d rounded half away from zero, saturated to the element range
	function automatic logic signed [EB-1:0] rdiv(logic signed [191:0] n, logic signed [191:0] d);
		logic signed [191:0] an, ad, q;
		logic signed [191:0] lim;
		bit neg;
		neg = (n < 0) != (d < 0);
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q = (2*an + ad) / (2*ad);
		lim = neg ? (192'sd1 <<< (EB-1)) : ((192'sd1 <<< (EB-1)) - 1);
		if (q > lim) q = lim;
		return neg ? EB'(-q) : EB'(q);
	endfunction

	task automatic predict_inverse();
		logic signed [191:0] a[3][3], cof[3][3], det, scale;
		logic signed [EB-1:0] dv, iv;
		bit sing;
		inv_word_t w;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				a[i][j] = elems[i*3+j];
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
					- a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
		det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
		scale = 192'sd1 <<< (2*FB);
		sing = (det == 0);
		dv = sing ? '0 : rdiv(det, scale);
		for (int k = 0; k < 9; k++) begin
			iv = sing ? '0 : rdiv(cof[k%3][k/3] * scale, det);
			w = '{row: 2'(k/3), col: 2'(k%3), inv: iv, det: dv, sing: sing, last: (k == 8)};
			expected_words.push_back(w);
		end
	endtask

	function automatic int gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	bit no_gaps = 0;

	// valid stays up between back-to-back words
	task automatic send_elem(logic signed [EB-1:0] v);
		int g;
		g = no_gaps ? 0 : gap();
		if (g > 0) begin
			s_axis_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= IW'(v);
		do @(posedge clk); while (!s_axis_tready);
		elems[load_cnt] = v;
		load_cnt++;
		if (load_cnt == 9) begin
			load_cnt = 0;
			predict_inverse();
		end
	endtask

	task automatic send_matrix(logic signed [EB-1:0] m[9]);
		for (int k = 0; k < 9; k++) send_elem(m[k]);
	endtask

	function automatic logic signed [EB-1:0] rand_small();
		return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
	endfunction

	function automatic logic signed [EB-1:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {1'b1, {(EB-1){1'b0}}};
			2: return {1'b0, {(EB-1){1'b1}}};
			default: return rand_small();
		endcase
	endfunction

	always @(posedge clk) begin
		inv_word_t got, exp_w;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.row = m_axis_tdata[1:0];
				got.col = m_axis_tdata[3:2];
				got.inv = m_axis_tdata[4 +: EB];
				got.det = m_axis_tdata[4+EB +: EB];
				got.sing = m_axis_tuser;
				got.last = m_axis_tlast;
				if (expected_words.size() == 0) begin
					$error("unexpected word row=%0d col=%0d", got.row, got.col);
					fails++;
				end else begin
					exp_w = expected_words.pop_front();
					if (got.row !== exp_w.row) begin
						$error("out_row expected %0d actual %0d", exp_w.row, got.row); fails++;
					end
					if (got.col !== exp_w.col) begin
						$error("out_col expected %0d actual %0d", exp_w.col, got.col); fails++;
					end
					if (got.inv !== exp_w.inv) begin
						$error("inv_value expected %0d actual %0d", $signed(exp_w.inv),
							$signed(got.inv)); fails++;
					end
					if (got.det !== exp_w.det) begin
						$error("det_value expected %0d actual %0d", $signed(exp_w.det),
							$signed(got.det)); fails++;
					end
					if (got.sing !== exp_w.sing) begin
						$error("singular expected %0d actual %0d", exp_w.sing, got.sing); fails++;
					end
					if (got.last !== exp_w.last) begin
						$error("last_out expected %0d actual %0d", exp_w.last, got.last); fails++;
					end
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("matrix_inverse_3x3: mismatch");
				$finish;
			end
		end
	end

	// receiver stalls: stretches of random gaps and stretches always ready
	always begin
		int g;
		@(posedge clk);
		if (rx_idle) begin
			m_axis_tready <= 1;
		end else begin
			g = gap();
			if (g > 0) begin
				m_axis_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_axis_tready <= 1;
		end
	end

	task automatic wait_drained();
		s_axis_tvalid <= 0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		logic signed [EB-1:0] m[9];
		localparam logic signed [EB-1:0] ONE = 1 << FB;
		localparam logic signed [EB-1:0] MAXV = {1'b0, {(EB-1){1'b1}}};
		localparam logic signed [EB-1:0] MINV = {1'b1, {(EB-1){1'b0}}};
		// identity
		m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
		send_matrix(m);
		// singular: all zeros
		m = '{default: 0};
		send_matrix(m);
		// tiny determinant, inverse saturates
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(m);
		// extremes of the element range
		m = '{MAXV, MINV, 0, MINV, MAXV, -1, 0, -1, MINV};
		send_matrix(m);
	endtask

	task automatic test_pause_drain();
		logic signed [EB-1:0] m[9];
		m = '{(1<<FB)/2, -(3<<FB), 1<<FB, 2<<FB, (1<<FB)/3, -1, 5, 7<<FB, -(1<<FB)};
		send_matrix(m);
		wait_drained();
		// no idling on either side for one matrix
		rx_idle = 1;
		no_gaps = 1;
		for (int k = 0; k < 9; k++) send_elem(rand_small());
		no_gaps = 0;
	endtask

	task automatic test_random();
		logic signed [EB-1:0] m[9];
		for (int n = 0; n < 22; n++) begin
			rx_idle = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 9; k++) m[k] = rand_elem();
			// rank-deficient rows now and then
			if ($urandom_range(0, 6) == 0)
				for (int k = 0; k < 3; k++) m[6+k] = m[k];
			send_matrix(m);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		rx_idle = 0;
		test_directed();
		test_pause_drain();
		test_random();
		wait_drained();
		repeat (400) @(posedge clk);
		if (fails == 0 && expected_words.size() == 0)
			$display("matrix_inverse_3x3: match");
		else
			$display("matrix_inverse_3x3: mismatch");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_fifo.sv
rtl/core/mi3_back.sv
rtl/core/matrix_inverse_3x3.sv
tb/tb.sv
